### hdl/compacting_extent_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef COMPACTING_EXTENT_ALLOCATOR_DEFINES_SVH
`define COMPACTING_EXTENT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// Plain property, checked every clock outside reset.
`define CEA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cea assertion failed");
// Same-cycle implication.
`define CEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cea assertion failed");
// Next-cycle implication.
`define CEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cea assertion failed");
`else
`define CEA_ASSERT(lbl, clk, rst_n, prop)
`define CEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/cea_pkg.sv
`default_nettype none

package cea_pkg;

  // table geometry
  localparam int MaxExtents = 128;
  localparam int IdxW       = $clog2(MaxExtents);
  localparam int CntW       = $clog2(MaxExtents + 1);

  // fixed field widths
  localparam int TagW    = 4;
  localparam int PosW    = 16;
  localparam int StatusW = 3;

  localparam logic [PosW-1:0] CapacityReset = PosW'(512);

  // request kinds
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StatusOk        = 3'd0,
    StatusTooLarge  = 3'd1,
    StatusNoSpace   = 3'd2,
    StatusNotFound  = 3'd3,
    StatusTableFull = 3'd4
  } status_e;

  // one table entry as held in memory
  typedef struct packed {
    logic [TagW-1:0] owner;
    logic [TagW-1:0] slot;
    logic [PosW-1:0] start;
    logic [PosW-1:0] len;
  } entry_t;

endpackage

`default_nettype wire

### hdl/cea_cfg_if.sv
`default_nettype none

interface cea_cfg_if;
  import cea_pkg::*;

  logic            valid;
  logic            ready;
  logic [PosW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/cea_req_if.sv
`default_nettype none

interface cea_req_if;
  import cea_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [TagW-1:0] owner_id;
  logic [TagW-1:0] file_slot;
  logic [PosW-1:0] request_size;

  modport source (output valid, output req_type, output owner_id, output file_slot,
                  output request_size, input ready);
  modport sink   (input valid, input req_type, input owner_id, input file_slot,
                  input request_size, output ready);
endinterface

`default_nettype wire

### hdl/cea_res_if.sv
`default_nettype none

interface cea_res_if;
  import cea_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [PosW-1:0]    start_pos;
  logic [PosW-1:0]    end_pos;
  logic [PosW-1:0]    free_space;

  modport source (output valid, output status, output start_pos, output end_pos,
                  output free_space, input ready);
  modport sink   (input valid, input status, input start_pos, input end_pos,
                  input free_space, output ready);
endinterface

`default_nettype wire

### hdl/compacting_extent_allocator.sv
// Compacting extent allocator.
// Channels: req_i takes one request beat (allocate or free, owner and file tags,
// size); res_o returns exactly one result beat per request (status, start, end,
// free units left). cfg_i writes the disk capacity and is always ready; the user
// writes it only while no request is in flight; the block does not enforce it.
// Flow: an allocate is accepted in StIdle, checked in StAlloc and handed to
// the output register from StDone, which waits while that register is full.
// A free streams the extent table out of one single-port-read memory, one
// entry per cycle, matching and shifting later entries down in the same pass;
// on an empty table it skips the scan and reports not found.
// One request is worked at a time; req_i.ready is high only when idle.
// The result sits in an output register, so a new request is taken while the
// previous result still waits; if res_o stalls, a second finished result holds
// in the block until the output register frees up.
// Reset: extent count and used space clear, capacity returns to 512. The table
// memory has no reset; only entries below the count are ever read.
`default_nettype none
`include "compacting_extent_allocator_defines.svh"

module compacting_extent_allocator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cea_cfg_if.sink    cfg_i,
  cea_req_if.sink    req_i,
  cea_res_if.source  res_o
);
  import cea_pkg::*;

  typedef enum logic [1:0] {StIdle, StAlloc, StScan, StDone} state_e;

  state_e state_q;

  logic [PosW-1:0] cap_q;
  logic [CntW-1:0] cnt_q;
  logic [PosW-1:0] used_q;

  // latched request
  logic [TagW-1:0] owner_q;
  logic [TagW-1:0] slot_q;
  logic [PosW-1:0] size_q;

  // scan pipeline
  logic [CntW-1:0] rd_cnt_q;
  logic            dv_q;
  logic [IdxW-1:0] didx_q;
  logic            found_q;
  logic [PosW-1:0] flen_q;
  logic [PosW-1:0] fstart_q;

  // pending result
  status_e         rstat_q;
  logic [PosW-1:0] rstart_q;
  logic [PosW-1:0] rend_q;

  // output register
  logic               out_vld_q;
  logic [StatusW-1:0] out_status_q;
  logic [PosW-1:0]    out_start_q;
  logic [PosW-1:0]    out_end_q;
  logic [PosW-1:0]    out_free_q;

  // extent table
  entry_t mem [MaxExtents];
  entry_t rdata_q;

  logic            req_acc;
  logic [PosW-1:0] free_w;
  logic            alloc_ok;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            match_now;
  logic            last_w;
  logic            hit_w;
  logic [PosW-1:0] hit_len;
  logic [PosW-1:0] hit_start;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            out_free_slot;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == StIdle);
  assign req_acc     = req_i.valid && req_i.ready;

  assign res_o.valid      = out_vld_q;
  assign res_o.status     = out_status_q;
  assign res_o.start_pos  = out_start_q;
  assign res_o.end_pos    = out_end_q;
  assign res_o.free_space = out_free_q;

  // free units, saturated at zero
  assign free_w = (cap_q > used_q) ? (cap_q - used_q) : '0;

  // allocate checks, in priority order
  assign alloc_ok = (size_q <= cap_q) && (size_q <= free_w) && (cnt_q < CntW'(MaxExtents));

  // scan read side
  assign rd_en   = (state_q == StScan) && (rd_cnt_q < cnt_q);
  assign rd_addr = rd_cnt_q[IdxW-1:0];

  // scan data side
  assign match_now = dv_q && !found_q && (rdata_q.owner == owner_q) && (rdata_q.slot == slot_q);
  assign last_w    = dv_q && (CntW'(didx_q) == (cnt_q - CntW'(1)));
  assign hit_w     = found_q || match_now;
  assign hit_len   = found_q ? flen_q   : rdata_q.len;
  assign hit_start = found_q ? fstart_q : rdata_q.start;

  // write port: append on allocate, shift down behind the match on free
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[IdxW-1:0];
    mem_wdata = '{owner: owner_q, slot: slot_q, start: used_q, len: size_q};
    if (state_q == StAlloc) begin
      mem_we = alloc_ok;
    end else if (state_q == StScan && dv_q && found_q) begin
      mem_we          = 1'b1;
      mem_waddr       = didx_q - IdxW'(1);
      mem_wdata       = rdata_q;
      mem_wdata.start = rdata_q.start - flen_q;
    end
  end

  // reads run ahead of the shift writes, so the same entry never overlaps
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_free_slot = !out_vld_q || res_o.ready;

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cap_q        <= CapacityReset;
      cnt_q        <= '0;
      used_q       <= '0;
      owner_q      <= '0;
      slot_q       <= '0;
      size_q       <= '0;
      rd_cnt_q     <= '0;
      dv_q         <= 1'b0;
      didx_q       <= '0;
      found_q      <= 1'b0;
      flen_q       <= '0;
      fstart_q     <= '0;
      rstat_q      <= StatusOk;
      rstart_q     <= '0;
      rend_q       <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= '0;
      out_start_q  <= '0;
      out_end_q    <= '0;
      out_free_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
      if (out_vld_q && res_o.ready && (state_q != StDone)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (req_acc) begin
            owner_q  <= req_i.owner_id;
            slot_q   <= req_i.file_slot;
            size_q   <= req_i.request_size;
            rd_cnt_q <= '0;
            dv_q     <= 1'b0;
            found_q  <= 1'b0;
            if (req_i.req_type == ReqAlloc) begin
              state_q <= StAlloc;
            end else if (cnt_q == '0) begin
              rstat_q  <= StatusNotFound;
              rstart_q <= '0;
              rend_q   <= '0;
              state_q  <= StDone;
            end else begin
              state_q <= StScan;
            end
          end
        end

        StAlloc: begin
          rstart_q <= '0;
          rend_q   <= '0;
          if (size_q > cap_q) begin
            rstat_q <= StatusTooLarge;
          end else if (size_q > free_w) begin
            rstat_q <= StatusNoSpace;
          end else if (!alloc_ok) begin
            rstat_q <= StatusTableFull;
          end else begin
            rstat_q  <= StatusOk;
            rstart_q <= used_q;
            rend_q   <= used_q + size_q;
            used_q   <= used_q + size_q;
            cnt_q    <= cnt_q + CntW'(1);
          end
          state_q <= StDone;
        end

        StScan: begin
          // the read side is already past the end when the last entry arrives
          dv_q   <= rd_en;
          didx_q <= rd_addr;
          if (rd_en) begin
            rd_cnt_q <= rd_cnt_q + CntW'(1);
          end
          if (match_now) begin
            found_q  <= 1'b1;
            flen_q   <= rdata_q.len;
            fstart_q <= rdata_q.start;
          end
          if (last_w) begin
            if (hit_w) begin
              rstat_q  <= StatusOk;
              rstart_q <= hit_start;
              rend_q   <= hit_start + hit_len;
              cnt_q    <= cnt_q - CntW'(1);
              used_q   <= (used_q >= hit_len) ? (used_q - hit_len) : '0;
            end else begin
              rstat_q  <= StatusNotFound;
              rstart_q <= '0;
              rend_q   <= '0;
            end
            state_q <= StDone;
          end
        end

        StDone: begin
          if (out_free_slot) begin
            out_vld_q    <= 1'b1;
            out_status_q <= rstat_q;
            out_start_q  <= rstart_q;
            out_end_q    <= rend_q;
            out_free_q   <= free_w;
            state_q      <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // checks
  `CEA_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(MaxExtents))
  `CEA_ASSERT_IMPL(a_shift_below_cnt, clk_i, rst_ni, mem_we && found_q, CntW'(didx_q) < cnt_q)
  `CEA_ASSERT_NEXT(a_used_grows, clk_i, rst_ni, mem_we && !found_q, used_q == $past(used_q + size_q))
  `CEA_ASSERT_IMPL(a_res_from_done, clk_i, rst_ni, $rose(out_vld_q), $past(state_q == StDone))

endmodule

`default_nettype wire
